[hw/rtl/clfb_pkg.sv]
// Shared constants, codes and types of the CRLF line framing buffer.
package clfb_pkg;

   // Buffer depth; must be a power of two so pointers wrap by truncation.
   localparam int unsigned DEPTH = 4096;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = PTR_W + 1;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Operation codes
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_PEEK   = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NO_LINE = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   // Newline tracker phases
   localparam logic [1:0] PH_NONE    = 2'd0;
   localparam logic [1:0] PH_CR      = 2'd1;
   localparam logic [1:0] PH_CRLF    = 2'd2;
   localparam logic [1:0] PH_CRLFCR  = 2'd3;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      logic [7:0]       wdata;
      logic             re;
      logic [PTR_W-1:0] raddr0;
      logic [PTR_W-1:0] raddr1;
   } ram_ctrl_type;

endpackage

[hw/rtl/clfb_channels.sv]
// Valid/ready channel interfaces for request and response words.
interface clfb_req_if
   import clfb_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [2:0]       op;
   logic [7:0]       data_byte;
   logic [PTR_W-1:0] index;
   logic [CNT_W-1:0] byte_count;

   modport source (output valid, output op, output data_byte, output index,
                   output byte_count, input ready);
   modport sink   (input valid, input op, input data_byte, input index,
                   input byte_count, output ready);
endinterface

interface clfb_rsp_if
   import clfb_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [7:0]       out_byte;
   logic             byte_valid;
   logic             end_of_line;
   logic [1:0]       status;
   logic [CNT_W-1:0] bytes_held;
   logic [CNT_W-1:0] lines_held;
   logic [CNT_W-1:0] empty_lines;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_line, output status, output bytes_held,
                   output lines_held, output empty_lines, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_line, input status, input bytes_held,
                   input lines_held, input empty_lines, output ready);
endinterface

[hw/rtl/clfb_byte_ram.sv]
// Byte store: one write port, two registered read ports with write bypass.
module clfb_byte_ram
   import clfb_pkg::*;
(
   input  logic         clock,
   input  ram_ctrl_type ctrl,
   output logic [7:0]   rd_data0,
   output logic [7:0]   rd_data1
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd0_ff;
   logic [7:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[ctrl.waddr] <= ctrl.wdata;
      end
      if (ctrl.re) begin
         rd0_ff <= (ctrl.we && ctrl.waddr == ctrl.raddr0) ? ctrl.wdata : mem[ctrl.raddr0];
         rd1_ff <= (ctrl.we && ctrl.waddr == ctrl.raddr1) ? ctrl.wdata : mem[ctrl.raddr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

[hw/rtl/crlf_line_framing_buffer.sv]
// Top level of the CRLF line framing buffer: control, counters and result register.
//
//   channel   direction  handshake           word contents
//   req_if    in         valid/ready         op, data_byte, index, byte_count
//   rsp_if    out        valid/ready         out_byte, byte_valid, end_of_line,
//                                            status, bytes_held, lines_held, empty_lines
//
// Push, pop, peek, clear and a remove that leaves at most one byte: request registered
// for execute, then the result registered; one word per cycle while rsp_if takes them.
// A remove that leaves N >= 2 bytes rescans them through read port 0, one byte a
// cycle, then finishes and registers the result; input held off meanwhile.
// Synchronous reset clears pointers, counters, tracker and handshake state, not the store.
// A stalled response holds in the result register; the next word waits in execute.
module crlf_line_framing_buffer
   import clfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   clfb_req_if.sink  req_if,
   clfb_rsp_if.source rsp_if
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   typedef struct packed {
      logic [2:0]       op;
      logic [7:0]       data_byte;
      logic [PTR_W-1:0] index;
      logic [CNT_W-1:0] byte_count;
   } item_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             end_of_line;
      logic [1:0]       status;
      logic [CNT_W-1:0] bytes_held;
      logic [CNT_W-1:0] lines_held;
      logic [CNT_W-1:0] empty_lines;
   } rsp_item_type;

   logic [1:0]       state_ff, state_in;
   item_type         item_ff, item_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] line_ff, line_in;
   logic [CNT_W-1:0] empty_ff, empty_in;
   logic [1:0]       phase_ff, phase_in;

   // recount scan
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [7:0]       prev_ff, prev_in;
   logic             have_prev_ff, have_prev_in;
   logic             rvld_ff, rvld_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   ram_ctrl_type     ram_ctrl;
   logic [7:0]       rd0, rd1;

   logic             out_free;
   logic             commit;
   logic             accept;
   logic [CNT_W-1:0] remain;
   logic [7:0]       res_byte;
   logic             res_valid;
   logic             res_eol;
   logic [1:0]       res_status;

   clfb_byte_ram u_ram (
      .clock    (clock),
      .ctrl     (ram_ctrl),
      .rd_data0 (rd0),
      .rd_data1 (rd1)
   );

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign remain   = fill_ff - item_ff.byte_count;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      line_in      = line_ff;
      empty_in     = empty_ff;
      phase_in     = phase_ff;
      iss_in       = iss_ff;
      scan_cnt_in  = scan_cnt_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      rvld_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      ram_ctrl     = '0;
      commit       = 1'b0;
      res_byte     = 8'd0;
      res_valid    = 1'b0;
      res_eol      = 1'b0;
      res_status   = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
         end

         S_EXEC: begin
            if (item_ff.op == OP_REMOVE && item_ff.byte_count < fill_ff &&
                remain > CNT_W'(1)) begin
               // drop front bytes now, then recount pairs in what is left
               head_in      = head_ff + item_ff.byte_count[PTR_W-1:0];
               fill_in      = remain;
               iss_in       = '0;
               scan_cnt_in  = '0;
               have_prev_in = 1'b0;
               state_in     = S_SCAN;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
               unique case (item_ff.op)
                  OP_PUSH: begin
                     if (fill_ff >= DEPTH_CNT) begin
                        res_status = ST_FULL;
                     end else begin
                        ram_ctrl.we    = 1'b1;
                        ram_ctrl.waddr = head_ff + fill_ff[PTR_W-1:0];
                        ram_ctrl.wdata = item_ff.data_byte;
                        fill_in        = fill_ff + CNT_W'(1);
                        // newline tracker: CR always opens a terminator
                        if (item_ff.data_byte == CH_CR) begin
                           phase_in = (phase_ff == PH_CRLF) ? PH_CRLFCR : PH_CR;
                        end else if (item_ff.data_byte == CH_LF) begin
                           if (phase_ff == PH_CR) begin
                              line_in  = line_ff + CNT_W'(1);
                              phase_in = PH_CRLF;
                           end else if (phase_ff == PH_CRLFCR) begin
                              line_in  = line_ff + CNT_W'(1);
                              phase_in = PH_CRLF;
                              if (empty_ff < DEPTH_CNT) begin
                                 empty_in = empty_ff + CNT_W'(1);
                              end
                           end else begin
                              phase_in = PH_NONE;
                           end
                        end else begin
                           phase_in = PH_NONE;
                        end
                     end
                  end
                  OP_POP: begin
                     if (line_ff == '0 || fill_ff == '0) begin
                        res_status = ST_NO_LINE;
                     end else if (fill_ff >= CNT_W'(2) && rd0 == CH_CR && rd1 == CH_LF) begin
                        head_in = head_ff + PTR_W'(2);
                        fill_in = fill_ff - CNT_W'(2);
                        line_in = line_ff - CNT_W'(1);
                        res_eol = 1'b1;
                     end else begin
                        res_byte  = rd0;
                        res_valid = 1'b1;
                        head_in   = head_ff + PTR_W'(1);
                        fill_in   = fill_ff - CNT_W'(1);
                     end
                  end
                  OP_PEEK: begin
                     if ({1'b0, item_ff.index} < fill_ff) begin
                        res_byte  = rd0;
                        res_valid = 1'b1;
                     end else begin
                        res_status = ST_RANGE;
                     end
                  end
                  OP_REMOVE: begin
                     if (item_ff.byte_count >= fill_ff) begin
                        head_in  = '0;
                        fill_in  = '0;
                        line_in  = '0;
                        empty_in = '0;
                        phase_in = PH_NONE;
                     end else begin
                        // at most one byte left: no pair possible
                        head_in = head_ff + item_ff.byte_count[PTR_W-1:0];
                        fill_in = remain;
                        line_in = '0;
                     end
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     fill_in  = '0;
                     line_in  = '0;
                     empty_in = '0;
                     phase_in = PH_NONE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue one read a cycle, compare each byte with the one before
            if (iss_ff != fill_ff) begin
               ram_ctrl.re     = 1'b1;
               ram_ctrl.raddr0 = head_ff + iss_ff[PTR_W-1:0];
               ram_ctrl.raddr1 = head_ff + iss_ff[PTR_W-1:0];
               iss_in          = iss_ff + CNT_W'(1);
               rvld_in         = 1'b1;
            end
            if (rvld_ff) begin
               if (have_prev_ff && prev_ff == CH_CR && rd0 == CH_LF) begin
                  scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               end
               prev_in      = rd0;
               have_prev_in = 1'b1;
            end
            if (iss_ff == fill_ff && !rvld_ff) begin
               line_in  = scan_cnt_ff;
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase

      if (commit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = res_byte;
         rsp_in.byte_valid  = res_valid;
         rsp_in.end_of_line = res_eol;
         rsp_in.status      = res_status;
         rsp_in.bytes_held  = fill_in;
         rsp_in.lines_held  = line_in;
         rsp_in.empty_lines = empty_in;
      end

      // take the next word when idle or on the edge the current one commits
      req_if.ready = (state_ff == S_IDLE) || commit;
      accept       = req_if.valid && req_if.ready;

      if (accept) begin
         item_in.op         = req_if.op;
         item_in.data_byte  = req_if.data_byte;
         item_in.index      = req_if.index;
         item_in.byte_count = req_if.byte_count;
         state_in           = S_EXEC;
         // read the front pair (or the peek target) from the committed head
         ram_ctrl.re        = 1'b1;
         ram_ctrl.raddr0    = (req_if.op == OP_PEEK) ? head_in + req_if.index : head_in;
         ram_ctrl.raddr1    = head_in + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         line_ff      <= '0;
         empty_ff     <= '0;
         phase_ff     <= PH_NONE;
         rvld_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         line_ff      <= line_in;
         empty_ff     <= empty_in;
         phase_ff     <= phase_in;
         rvld_ff      <= rvld_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      iss_ff      <= iss_in;
      scan_cnt_ff <= scan_cnt_in;
      prev_ff     <= prev_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_byte    = rsp_ff.out_byte;
   assign rsp_if.byte_valid  = rsp_ff.byte_valid;
   assign rsp_if.end_of_line = rsp_ff.end_of_line;
   assign rsp_if.status      = rsp_ff.status;
   assign rsp_if.bytes_held  = rsp_ff.bytes_held;
   assign rsp_if.lines_held  = rsp_ff.lines_held;
   assign rsp_if.empty_lines = rsp_ff.empty_lines;

endmodule

[tb/clfb_checker.sv]
// Checker of the CRLF line framing buffer: shadow buffer, expected response words, compare.
module clfb_checker
   import clfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [2:0]       req_op,
   input  logic [7:0]       req_data_byte,
   input  logic [PTR_W-1:0] req_index,
   input  logic [CNT_W-1:0] req_byte_count,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [7:0]       rsp_out_byte,
   input  logic             rsp_byte_valid,
   input  logic             rsp_end_of_line,
   input  logic [1:0]       rsp_status,
   input  logic [CNT_W-1:0] rsp_bytes_held,
   input  logic [CNT_W-1:0] rsp_lines_held,
   input  logic [CNT_W-1:0] rsp_empty_lines,
   output int unsigned      mismatch_count,
   output int unsigned      words_pending
);

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             end_of_line;
      logic [1:0]       status;
      logic [CNT_W-1:0] bytes_held;
      logic [CNT_W-1:0] lines_held;
      logic [CNT_W-1:0] empty_lines;
   } line_rsp_type;

   line_rsp_type     expected_rsps[$];
   line_rsp_type     want;
   logic [7:0]       shadow_store [DEPTH];
   logic [PTR_W-1:0] shadow_head;
   logic [CNT_W-1:0] shadow_fill;
   logic [CNT_W-1:0] shadow_lines;
   logic [CNT_W-1:0] shadow_empties;
   logic [1:0]       shadow_phase;
   int unsigned      errors = 0;

   function automatic logic [7:0] byte_at(logic [CNT_W-1:0] off);
      return shadow_store[PTR_W'(shadow_head + off)];
   endfunction

   function automatic void empty_buffer();
      shadow_head    = '0;
      shadow_fill    = '0;
      shadow_lines   = '0;
      shadow_empties = '0;
      shadow_phase   = PH_NONE;
   endfunction

   function automatic void track_newline(logic [7:0] b);
      if (b == CH_CR) begin
         shadow_phase = (shadow_phase == PH_CRLF) ? PH_CRLFCR : PH_CR;
      end else if (b == CH_LF) begin
         if (shadow_phase == PH_CR) begin
            shadow_lines++;
            shadow_phase = PH_CRLF;
         end else if (shadow_phase == PH_CRLFCR) begin
            shadow_lines++;
            if (shadow_empties < DEPTH_CNT) shadow_empties++;
            shadow_phase = PH_CRLF;
         end else begin
            shadow_phase = PH_NONE;
         end
      end else begin
         shadow_phase = PH_NONE;
      end
   endfunction

   function automatic line_rsp_type predict_rsp(logic [2:0] op, logic [7:0] b,
                                                logic [PTR_W-1:0] ix, logic [CNT_W-1:0] n);
      line_rsp_type     r;
      int unsigned      i;
      logic [CNT_W-1:0] pairs;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (shadow_fill >= DEPTH_CNT) begin
               r.status = ST_FULL;
            end else begin
               shadow_store[PTR_W'(shadow_head + shadow_fill)] = b;
               shadow_fill++;
               track_newline(b);
            end
         end
         OP_POP: begin
            if (shadow_lines == 0 || shadow_fill == 0) begin
               r.status = ST_NO_LINE;
            end else if (shadow_fill >= 2 && byte_at(0) == CH_CR && byte_at(1) == CH_LF) begin
               shadow_head  = shadow_head + PTR_W'(2);
               shadow_fill  = shadow_fill - CNT_W'(2);
               shadow_lines = shadow_lines - CNT_W'(1);
               r.end_of_line = 1'b1;
            end else begin
               r.out_byte   = byte_at(0);
               r.byte_valid = 1'b1;
               shadow_head  = shadow_head + PTR_W'(1);
               shadow_fill  = shadow_fill - CNT_W'(1);
            end
         end
         OP_PEEK: begin
            if (CNT_W'(ix) < shadow_fill) begin
               r.out_byte   = byte_at(CNT_W'(ix));
               r.byte_valid = 1'b1;
            end else begin
               r.status = ST_RANGE;
            end
         end
         OP_REMOVE: begin
            if (n >= shadow_fill) begin
               empty_buffer();
            end else begin
               shadow_head = shadow_head + PTR_W'(n);
               shadow_fill = shadow_fill - n;
               pairs = '0;
               for (i = 1; i < shadow_fill; i++)
                  if (byte_at(CNT_W'(i)) == CH_LF && byte_at(CNT_W'(i - 1)) == CH_CR) pairs++;
               shadow_lines = pairs;
            end
         end
         OP_CLEAR: empty_buffer();
         default: ;
      endcase
      r.bytes_held  = shadow_fill;
      r.lines_held  = shadow_lines;
      r.empty_lines = shadow_empties;
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_rsps.delete();
         empty_buffer();
      end else begin
         if (req_valid && req_ready)
            expected_rsps.insert(expected_rsps.size(),
                                 predict_rsp(req_op, req_data_byte, req_index, req_byte_count));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response word with no request waiting");
               errors++;
            end else begin
               want = expected_rsps[0];
               expected_rsps.delete(0);
               check_field("out_byte", 16'(want.out_byte), 16'(rsp_out_byte));
               check_field("byte_valid", 16'(want.byte_valid), 16'(rsp_byte_valid));
               check_field("end_of_line", 16'(want.end_of_line), 16'(rsp_end_of_line));
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("bytes_held", 16'(want.bytes_held), 16'(rsp_bytes_held));
               check_field("lines_held", 16'(want.lines_held), 16'(rsp_lines_held));
               check_field("empty_lines", 16'(want.empty_lines), 16'(rsp_empty_lines));
            end
         end
      end
      mismatch_count <= errors;
      words_pending  <= expected_rsps.size();
   end

endmodule

[tb/tb_top.sv]
// Top of the CRLF line framing buffer testbench: clock, reset, stimulus and verdict.
module tb_top;
   import clfb_pkg::*;

   // Generous bound; the slowest correct run stays far below it.
   localparam int unsigned CYCLE_LIMIT = 600000;
   // Response-side quiet time before the verdict.
   localparam int unsigned DRAIN_CYCLES = 50;
   // Length of the one long receiver hold-off.
   localparam int unsigned HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;

   clfb_req_if req_if ();
   clfb_rsp_if rsp_if ();

   int unsigned mismatch_count;
   int unsigned words_pending;
   int unsigned cycle_count = 0;

   // Idle rates in percent; changed by the stimulus with nonblocking writes.
   int unsigned send_idle_pct = 21;
   int unsigned rcv_idle_pct  = 51;

   // Long hold-off: requested once by the stimulus, counted by the receiver.
   logic        hold_request = 1'b0;
   logic        hold_done    = 1'b0;
   int unsigned hold_left    = 0;

   crlf_line_framing_buffer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   clfb_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_op          (req_if.op),
      .req_data_byte   (req_if.data_byte),
      .req_index       (req_if.index),
      .req_byte_count  (req_if.byte_count),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_out_byte    (rsp_if.out_byte),
      .rsp_byte_valid  (rsp_if.byte_valid),
      .rsp_end_of_line (rsp_if.end_of_line),
      .rsp_status      (rsp_if.status),
      .rsp_bytes_held  (rsp_if.bytes_held),
      .rsp_lines_held  (rsp_if.lines_held),
      .rsp_empty_lines (rsp_if.empty_lines),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run; a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // Offer one word and hold it until accepted. Idle cycles come first, so
   // valid is only ever written once per edge.
   task automatic send_word(logic [2:0] op, logic [7:0] b, logic [PTR_W-1:0] ix,
                            logic [CNT_W-1:0] n);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.data_byte  <= b;
      req_if.index      <= ix;
      req_if.byte_count <= n;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Unused fields still get random values so every bit toggles.
   function automatic logic [PTR_W-1:0] any_index();
      return PTR_W'($urandom_range(0, DEPTH - 1));
   endfunction

   function automatic logic [CNT_W-1:0] any_count();
      return CNT_W'($urandom_range(0, DEPTH));
   endfunction

   task automatic push_byte(logic [7:0] b);
      send_word(OP_PUSH, b, any_index(), any_count());
   endtask

   task automatic send_op(logic [2:0] op);
      send_word(op, 8'($urandom), any_index(), any_count());
   endtask

   // Line content leans on CR and LF so stray and split terminators show up.
   function automatic logic [7:0] line_byte();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) return CH_CR;
      if (pick < 35) return CH_LF;
      return 8'($urandom);
   endfunction

   task automatic push_line(int unsigned len);
      repeat (len) push_byte(line_byte());
      push_byte(CH_CR);
      push_byte(CH_LF);
   endtask

   // Mostly framed lines and pops that drain them; some peeks, removes,
   // clears and raw noise on top.
   task automatic random_phase(int unsigned sequences);
      int unsigned kind;
      repeat (sequences) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            push_line($urandom_range(0, 8));
            if ($urandom_range(0, 3) == 0) begin
               push_byte(CH_CR);
               push_byte(CH_LF);
            end
         end else if (kind < 75) begin
            repeat ($urandom_range(1, 10)) send_op(OP_POP);
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 3))
               send_word(OP_PEEK, 8'($urandom),
                         ($urandom_range(0, 7) == 0) ? any_index()
                                                     : PTR_W'($urandom_range(0, 40)),
                         any_count());
         end else if (kind < 91) begin
            send_word(OP_REMOVE, 8'($urandom), any_index(),
                      ($urandom_range(0, 9) == 0) ? any_count()
                                                  : CNT_W'($urandom_range(0, 6)));
         end else if (kind < 93) begin
            send_op(OP_CLEAR);
         end else begin
            send_word(3'($urandom_range(0, 7)), 8'($urandom), any_index(), any_count());
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.op         = OP_PUSH;
      req_if.data_byte  = '0;
      req_if.index      = '0;
      req_if.byte_count = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-buffer corners, tracker walk, terminator pops.
      send_op(OP_POP);                               // no complete line
      send_word(OP_PEEK, 8'h00, '0, any_count());    // peek on empty
      send_word(OP_REMOVE, 8'h00, any_index(), '0);  // remove 0 from empty acts as clear
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CH_CR);
      push_byte(CH_CR);                              // CR after CR restarts the terminator
      push_byte(CH_LF);                              // first line
      push_byte(CH_CR);
      push_byte(CH_LF);                              // empty line
      push_byte(CH_LF);                              // LF after CR LF resets the tracker
      push_byte(8'h41);
      send_word(OP_PEEK, 8'h00, PTR_W'(DEPTH - 1), any_count());  // beyond end
      send_word(OP_PEEK, 8'h00, PTR_W'(2), any_count());
      send_op(OP_POP);
      send_op(OP_POP);
      send_op(OP_POP);                               // lone CR pops as a plain byte
      send_op(OP_POP);                               // consume CR LF
      send_op(OP_POP);                               // consume the empty line
      send_op(OP_POP);                               // nothing framed left
      send_word(OP_REMOVE, 8'h00, any_index(), CNT_W'(1));
      send_op(3'd5);
      send_op(3'd7);
      send_word(OP_REMOVE, 8'h00, any_index(), DEPTH_CNT);
      send_op(OP_CLEAR);

      random_phase(50);

      // Swap the idle rates.
      send_idle_pct <= 51;
      rcv_idle_pct  <= 21;
      random_phase(50);

      // No idling; start with the long hold-off so the block backs up.
      send_idle_pct <= 0;
      rcv_idle_pct  <= 0;
      hold_request  <= 1'b1;
      random_phase(50);

      // Back to mixed traffic with gaps on both sides.
      send_idle_pct <= 21;
      rcv_idle_pct  <= 51;
      random_phase(30);

      // Drop valid, then wait for the last responses and a quiet tail.
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && words_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
